// ===== sv/dqvd_pkg.sv =====
// Shared types and codes for the double-ended queue with delete-by-value.
// Used by dqvd_cell, deque_with_value_delete and the testbench; depends on nothing else.
package dqvd_pkg;

   // Opcodes carried by an input item.
   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_POP_BACK   = 3'd1;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_DELETE     = 3'd4;

   // Status codes carried by a result item.
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NOMATCH = 2'd3;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OCC_W   = 5;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] data_out;
      logic [1:0]         status;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

   // Command broadcast to every cell of the row.
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_PUSH_BACK,
      CMD_PUSH_FRONT,
      CMD_POP_BACK,
      CMD_POP_FRONT,
      CMD_DELETE
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } cell_ctrl_type;

endpackage

// ===== sv/dqvd_cell.sv =====
// One slot of the queue: a data word, its valid bit and the local match logic.
// Depends on dqvd_pkg for the command type.
module dqvd_cell #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dqvd_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]   value,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic                    left_valid,
   input  logic [DATA_WIDTH-1:0]   right_data,
   input  logic                    right_valid,
   input  logic                    hit_in,
   output logic [DATA_WIDTH-1:0]   data,
   output logic                    valid,
   output logic                    hit_out,
   output logic                    tail
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;

   // A match here or in any cell nearer the front marks this cell for the shift.
   assign hit_out = hit_in | (valid_ff && (data_ff == value));
   assign tail    = valid_ff & ~right_valid;
   assign data    = data_ff;
   assign valid   = valid_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (ctrl.cmd)
         dqvd_pkg::CMD_PUSH_BACK: begin
            if (!valid_ff && left_valid) begin
               data_in  = value;
               valid_in = 1'b1;
            end
         end
         dqvd_pkg::CMD_PUSH_FRONT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         dqvd_pkg::CMD_POP_BACK: begin
            if (tail) begin
               valid_in = 1'b0;
            end
         end
         dqvd_pkg::CMD_POP_FRONT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         dqvd_pkg::CMD_DELETE: begin
            if (hit_out) begin
               data_in  = right_data;
               valid_in = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== sv/deque_with_value_delete.sv =====
// Bounded double-ended queue with delete of the first matching entry.
// The result item is presented in the cycle after its input item is accepted.
// Throughput: one item per cycle unless the result side stalls; every operation is a
// single cell-row update, and the delete search ripples a match flag through the cells in it.
// Reset (synchronous, active high) clears the valid bits, the entry count and the
// result valid flag at once; there is no clearing pass. Depends on dqvd_pkg, dqvd_cell.
module deque_with_value_delete #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dqvd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dqvd_pkg::rsp_type rsp_data
);

   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned EXT_W = DATA_WIDTH + dqvd_pkg::VALUE_W;
   localparam int unsigned CEXT  = CW + dqvd_pkg::OCC_W;

   // The row of cells is wired as a chain. Position 0 of the chain carries the
   // incoming word as a always-valid left neighbor of the front cell, which makes
   // push front and push into an empty queue fall out of the same cell logic.
   // The last position is an always-empty right neighbor of the back cell.
   logic [DATA_WIDTH-1:0] chain_data  [0:DEPTH+1];
   logic [DEPTH+1:0]      chain_valid;
   logic [DEPTH:0]        hit_chain;
   logic [DEPTH-1:0]      tail_vec;
   logic [DEPTH-1:0]      valid_vec;

   logic [EXT_W-1:0]      value_ext;
   logic [DATA_WIDTH-1:0] value_word;

   logic [CW-1:0]         count_ff, count_in;
   logic                  full, empty, accept;

   dqvd_pkg::cmd_type       cmd;
   dqvd_pkg::cell_ctrl_type ctrl;
   logic [1:0]              status;
   logic [DATA_WIDTH-1:0]   pop_word, tail_word;
   logic [EXT_W-1:0]        pop_ext;
   logic [CEXT-1:0]         count_ext;

   logic                    rsp_valid_ff;
   dqvd_pkg::rsp_type       rsp_data_ff;

   // The input word is kept to DATA_WIDTH bits, zero-extended when that is wider.
   assign value_ext  = EXT_W'(req_data.value);
   assign value_word = value_ext[DATA_WIDTH-1:0];

   assign chain_data[0]          = value_word;
   assign chain_valid[0]         = 1'b1;
   assign chain_data[DEPTH+1]    = '0;
   assign chain_valid[DEPTH+1]   = 1'b0;
   assign hit_chain[0]           = 1'b0;
   assign valid_vec              = chain_valid[DEPTH:1];

   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign accept = req_valid && req_ready;

   // The result register is free when empty or being drained in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      dqvd_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .value      (value_word),
         .left_data  (chain_data[i]),
         .left_valid (chain_valid[i]),
         .right_data (chain_data[i+2]),
         .right_valid(chain_valid[i+2]),
         .hit_in     (hit_chain[i]),
         .data       (chain_data[i+1]),
         .valid      (chain_valid[i+1]),
         .hit_out    (hit_chain[i+1]),
         .tail       (tail_vec[i])
      );
   end

   // The back entry is the one valid cell whose right neighbor is empty, so the
   // tail flags are one-hot and an OR of the masked words selects it.
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | ({DATA_WIDTH{tail_vec[i]}} & chain_data[i+1]);
      end
   end

   // Decode the item into a row command, a status and the next entry count.
   // Operations that cannot take effect become a no-op for the cells.
   always_comb begin
      cmd      = dqvd_pkg::CMD_NOP;
      status   = dqvd_pkg::ST_DONE;
      count_in = count_ff;
      pop_word = '0;
      case (req_data.opcode)
         dqvd_pkg::OP_PUSH_BACK, dqvd_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status = dqvd_pkg::ST_FULL;
            end else begin
               cmd      = (req_data.opcode == dqvd_pkg::OP_PUSH_BACK) ?
                          dqvd_pkg::CMD_PUSH_BACK : dqvd_pkg::CMD_PUSH_FRONT;
               count_in = count_ff + 1'b1;
            end
         end
         dqvd_pkg::OP_POP_BACK: begin
            if (empty) begin
               status = dqvd_pkg::ST_EMPTY;
            end else begin
               cmd      = dqvd_pkg::CMD_POP_BACK;
               pop_word = tail_word;
               count_in = count_ff - 1'b1;
            end
         end
         dqvd_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status = dqvd_pkg::ST_EMPTY;
            end else begin
               cmd      = dqvd_pkg::CMD_POP_FRONT;
               pop_word = chain_data[1];
               count_in = count_ff - 1'b1;
            end
         end
         dqvd_pkg::OP_DELETE: begin
            // The match flag leaving the back cell tells whether any entry matched.
            if (hit_chain[DEPTH]) begin
               cmd      = dqvd_pkg::CMD_DELETE;
               count_in = count_ff - 1'b1;
            end else begin
               status = dqvd_pkg::ST_NOMATCH;
            end
         end
         default: begin
         end
      endcase
   end

   // Cells only move on an accepted item.
   assign ctrl.cmd  = accept ? cmd : dqvd_pkg::CMD_NOP;

   assign pop_ext   = EXT_W'(pop_word);
   assign count_ext = CEXT'(count_in);

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.data_out  <= pop_ext[dqvd_pkg::VALUE_W-1:0];
         rsp_data_ff.status    <= status;
         rsp_data_ff.occupancy <= count_ext[dqvd_pkg::OCC_W-1:0];
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Occupied cells always form an unbroken run from the front.
   a_valid_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("valid cells are not contiguous from the front");

   // The entry count tracks the number of occupied cells.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("entry count disagrees with the cell row");

   // A dropped push is only reported when the row is really full.
   a_full_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == dqvd_pkg::ST_FULL) |-> full)
      else $error("full status reported while the row has room");

   // An accepted pop on a non-empty queue removes exactly one entry.
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && !empty && ((req_data.opcode == dqvd_pkg::OP_POP_BACK) ||
                           (req_data.opcode == dqvd_pkg::OP_POP_FRONT))
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not remove one entry");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for deque_with_value_delete: a directed opening, then biased random
// push, pop, delete and unused-opcode traffic with random stalls on both channels, all checked in-line.
// Depends on dqvd_pkg and the deque_with_value_delete RTL.
module testbench;

   localparam int unsigned DEQUE_DEPTH  = 16;
   localparam int unsigned RANDOM_ITEMS = 1200;
   // Cycles with no item accepted on either channel before the run is declared hung.
   localparam int unsigned STALL_LIMIT  = 2000;
   // The block ignores these opcodes; they cover the unused part of the opcode field.
   localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
   localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
   // Window of accepted items in which neither side idles.
   localparam int unsigned STEADY_FROM  = 600;
   localparam int unsigned STEADY_TO    = 800;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   dqvd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   dqvd_pkg::rsp_type rsp_data;

   // Items waiting to be offered, filled once at time zero.
   dqvd_pkg::req_type stimulus_items[$];
   // Results the deque must still produce, oldest first.
   dqvd_pkg::rsp_type awaited_results[$];
   // Shadow copy of the deque contents, front at index 0.
   logic [31:0] held_words[$];
   // Words pushed recently by the stimulus, so deletes often find a match.
   logic [31:0] recent_words[$];

   int unsigned item_total;
   int unsigned accepted_items;
   int unsigned stalled_cycles;
   int unsigned mismatch_count;
   logic        item_taken;
   wire         steady_run = (accepted_items >= STEADY_FROM) && (accepted_items < STEADY_TO);

   deque_with_value_delete #(
      .DEPTH      (DEQUE_DEPTH),
      .DATA_WIDTH (32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Applies one operation to the shadow deque and returns the result the block should give.
   // Full pushes, empty pops, missed deletes and unused opcodes leave the contents alone.
   function automatic dqvd_pkg::rsp_type next_deque_result(dqvd_pkg::req_type item);
      dqvd_pkg::rsp_type outcome;
      int                hit;
      outcome.data_out = '0;
      outcome.status   = dqvd_pkg::ST_DONE;
      hit = -1;
      case (item.opcode)
         dqvd_pkg::OP_PUSH_BACK, dqvd_pkg::OP_PUSH_FRONT: begin
            if (held_words.size() >= DEQUE_DEPTH)
               outcome.status = dqvd_pkg::ST_FULL;
            else if (item.opcode == dqvd_pkg::OP_PUSH_BACK)
               held_words.push_back(item.value);
            else
               held_words.push_front(item.value);
         end
         dqvd_pkg::OP_POP_BACK: begin
            if (held_words.size() == 0)
               outcome.status = dqvd_pkg::ST_EMPTY;
            else
               outcome.data_out = held_words.pop_back();
         end
         dqvd_pkg::OP_POP_FRONT: begin
            if (held_words.size() == 0)
               outcome.status = dqvd_pkg::ST_EMPTY;
            else
               outcome.data_out = held_words.pop_front();
         end
         dqvd_pkg::OP_DELETE: begin
            // Only the first equal entry, counted from the front, goes away.
            foreach (held_words[i])
               if (hit < 0 && held_words[i] == item.value)
                  hit = i;
            if (hit < 0)
               outcome.status = dqvd_pkg::ST_NOMATCH;
            else
               held_words.delete(hit);
         end
         default: begin
         end
      endcase
      outcome.occupancy = 5'(held_words.size());
      return outcome;
   endfunction

   // Queues one item for the driver and remembers pushed words for later deletes.
   task automatic add_item(logic [2:0] opcode, logic [31:0] value);
      dqvd_pkg::req_type item;
      item.opcode = opcode;
      item.value  = value;
      stimulus_items.push_back(item);
      if (opcode == dqvd_pkg::OP_PUSH_BACK || opcode == dqvd_pkg::OP_PUSH_FRONT) begin
         recent_words.push_back(value);
         if (recent_words.size() > DEQUE_DEPTH)
            void'(recent_words.pop_front());
      end
   endtask

   // Stimulus and end of run.
   initial begin
      int unsigned lean;
      int unsigned roll;
      int unsigned push_limit;
      int unsigned pop_limit;
      logic [2:0]  opcode;
      logic [31:0] value;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      item_taken     = 1'b0;
      accepted_items = 0;
      stalled_cycles = 0;
      mismatch_count = 0;

      // Directed opening. Pops and a delete on the empty deque come first.
      add_item(dqvd_pkg::OP_POP_BACK, 32'h0000_0000);
      add_item(dqvd_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
      add_item(dqvd_pkg::OP_DELETE, 32'h0000_0000);
      // Extreme words at both ends, and the unused opcodes between them.
      add_item(dqvd_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
      add_item(dqvd_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      add_item(OP_UNUSED_LO, 32'hFFFF_FFFF);
      add_item(OP_UNUSED_HI, 32'h0000_0000);
      // Fill to capacity from both ends, with repeated all-ones words so that a
      // delete has more than one candidate.
      for (int i = 0; i < DEQUE_DEPTH - 2; i++)
         add_item(i[0] ? dqvd_pkg::OP_PUSH_FRONT : dqvd_pkg::OP_PUSH_BACK,
                  (i % 5 == 0) ? 32'hFFFF_FFFF : $urandom);
      // Pushes into the full deque are dropped.
      add_item(dqvd_pkg::OP_PUSH_FRONT, 32'h1234_5678);
      add_item(dqvd_pkg::OP_PUSH_BACK, 32'h8000_0000);
      // The delete removes the frontmost all-ones word from the middle and closes the gap.
      add_item(dqvd_pkg::OP_DELETE, 32'hFFFF_FFFF);
      add_item(dqvd_pkg::OP_POP_BACK, 32'h0000_0000);
      add_item(dqvd_pkg::OP_POP_FRONT, 32'h0000_0000);

      // Random part in phases that lean toward filling, draining, or neither, so the
      // deque keeps reaching both the full and the empty state.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         lean = (n / 80) % 3;
         push_limit = (lean == 0) ? 60 : (lean == 1) ? 20 : 40;
         pop_limit  = (lean == 2) ? 70 : 75;
         roll = $urandom_range(99);
         if (roll < push_limit) begin
            opcode = $urandom_range(1) ? dqvd_pkg::OP_PUSH_BACK : dqvd_pkg::OP_PUSH_FRONT;
            roll = $urandom_range(99);
            if (roll < 15 && recent_words.size() > 0)
               value = recent_words[$urandom_range(recent_words.size() - 1)];
            else if (roll < 25)
               value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            else
               value = $urandom;
         end else if (roll < pop_limit) begin
            opcode = $urandom_range(1) ? dqvd_pkg::OP_POP_BACK : dqvd_pkg::OP_POP_FRONT;
            value  = $urandom;
         end else if (roll < 93) begin
            opcode = dqvd_pkg::OP_DELETE;
            if ($urandom_range(99) < 70 && recent_words.size() > 0)
               value = recent_words[$urandom_range(recent_words.size() - 1)];
            else
               value = $urandom;
         end else begin
            opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            value  = $urandom;
         end
         add_item(opcode, value);
      end
      item_total = stimulus_items.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Everything accepted and answered; the counters settle at the rising edge,
      // so they are read at the falling one.
      while (accepted_items < item_total || awaited_results.size() != 0)
         @(negedge clock);
      // Then wait on to catch any stray result after the last one.
      repeat (8) @(negedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Driver. Inputs change on the falling edge. A new item is offered only when the
   // previous one was taken at the last rising edge or nothing was on offer; an offered
   // item holds until it is accepted. Both sides idle at random outside the steady window.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         if (stimulus_items.size() > 0 && (steady_run || $urandom_range(99) >= 32)) begin
            req_data  <= stimulus_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= steady_run || ($urandom_range(99) >= 32);
   end

   // Monitor. Samples both handshakes at the rising edge. An accepted input item is run
   // through the shadow deque at once, and every accepted result is compared with the
   // oldest expectation. The result for an item shows up in the following cycle at the earliest,
   // so the order of the two steps below never matters for correct hardware.
   always @(posedge clock) begin
      dqvd_pkg::rsp_type expected;
      item_taken = req_valid && req_ready;
      if (!reset) begin
         if (item_taken) begin
            awaited_results.push_back(next_deque_result(req_data));
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result item with none expected: data_out %h status %0d occupancy %0d",
                      rsp_data.data_out, rsp_data.status, rsp_data.occupancy);
               mismatch_count++;
            end else begin
               expected = awaited_results.pop_front();
               if (rsp_data.data_out !== expected.data_out) begin
                  $error("data_out: expected %h, got %h", expected.data_out, rsp_data.data_out);
                  mismatch_count++;
               end
               if (rsp_data.status !== expected.status) begin
                  $error("status: expected %0d, got %0d", expected.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.occupancy !== expected.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         expected.occupancy, rsp_data.occupancy);
                  mismatch_count++;
               end
            end
         end
         // Watchdog: a long run of cycles with no handshake on either side means a hang.
         if (item_taken || (rsp_valid && rsp_ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

endmodule

// ===== sim.f =====
sv/dqvd_pkg.sv
sv/dqvd_cell.sv
sv/deque_with_value_delete.sv
test/testbench.sv
